@@ hw/rtl/assert_macros.svh @@
// Assertion macros shared by the hasher RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on an explicit clock, disabled while reset is low.
`define SHA_ASSERT_CLK(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("assertion failed");

// Check a property on the module clock clk_i and reset rst_ni.
`define SHA_ASSERT(lbl, prop) `SHA_ASSERT_CLK(lbl, clk_i, rst_ni, prop)

`endif

@@ hw/rtl/sha256h_pkg.sv @@
// Types, constants and bit functions shared by the SHA-256 hasher.
package sha256h_pkg;

  typedef logic [7:0][31:0] hash_t;

  // Control from the sequencer to the compression core.
  typedef struct packed {
    logic       push;
    logic [7:0] push_byte;
    logic       start;
    logic       init;
  } core_ctrl_t;

  // Status from the compression core.
  typedef struct packed {
    logic busy;
    logic done;
  } core_stat_t;

  localparam hash_t SHA_IV = {
    32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
    32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
  };

  localparam logic [7:0] PAD_BYTE   = 8'h80;
  localparam logic [5:0] LEN_OFFSET = 6'd56;

  function automatic logic [31:0] round_const(input logic [5:0] idx);
    logic [31:0] k;
    unique case (idx)
      6'd0:  k = 32'h428a2f98;  6'd1:  k = 32'h71374491;
      6'd2:  k = 32'hb5c0fbcf;  6'd3:  k = 32'he9b5dba5;
      6'd4:  k = 32'h3956c25b;  6'd5:  k = 32'h59f111f1;
      6'd6:  k = 32'h923f82a4;  6'd7:  k = 32'hab1c5ed5;
      6'd8:  k = 32'hd807aa98;  6'd9:  k = 32'h12835b01;
      6'd10: k = 32'h243185be;  6'd11: k = 32'h550c7dc3;
      6'd12: k = 32'h72be5d74;  6'd13: k = 32'h80deb1fe;
      6'd14: k = 32'h9bdc06a7;  6'd15: k = 32'hc19bf174;
      6'd16: k = 32'he49b69c1;  6'd17: k = 32'hefbe4786;
      6'd18: k = 32'h0fc19dc6;  6'd19: k = 32'h240ca1cc;
      6'd20: k = 32'h2de92c6f;  6'd21: k = 32'h4a7484aa;
      6'd22: k = 32'h5cb0a9dc;  6'd23: k = 32'h76f988da;
      6'd24: k = 32'h983e5152;  6'd25: k = 32'ha831c66d;
      6'd26: k = 32'hb00327c8;  6'd27: k = 32'hbf597fc7;
      6'd28: k = 32'hc6e00bf3;  6'd29: k = 32'hd5a79147;
      6'd30: k = 32'h06ca6351;  6'd31: k = 32'h14292967;
      6'd32: k = 32'h27b70a85;  6'd33: k = 32'h2e1b2138;
      6'd34: k = 32'h4d2c6dfc;  6'd35: k = 32'h53380d13;
      6'd36: k = 32'h650a7354;  6'd37: k = 32'h766a0abb;
      6'd38: k = 32'h81c2c92e;  6'd39: k = 32'h92722c85;
      6'd40: k = 32'ha2bfe8a1;  6'd41: k = 32'ha81a664b;
      6'd42: k = 32'hc24b8b70;  6'd43: k = 32'hc76c51a3;
      6'd44: k = 32'hd192e819;  6'd45: k = 32'hd6990624;
      6'd46: k = 32'hf40e3585;  6'd47: k = 32'h106aa070;
      6'd48: k = 32'h19a4c116;  6'd49: k = 32'h1e376c08;
      6'd50: k = 32'h2748774c;  6'd51: k = 32'h34b0bcb5;
      6'd52: k = 32'h391c0cb3;  6'd53: k = 32'h4ed8aa4a;
      6'd54: k = 32'h5b9cca4f;  6'd55: k = 32'h682e6ff3;
      6'd56: k = 32'h748f82ee;  6'd57: k = 32'h78a5636f;
      6'd58: k = 32'h84c87814;  6'd59: k = 32'h8cc70208;
      6'd60: k = 32'h90befffa;  6'd61: k = 32'ha4506ceb;
      6'd62: k = 32'hbef9a3f7;  6'd63: k = 32'hc67178f2;
      default: k = 32'h0;
    endcase
    return k;
  endfunction

  function automatic logic [31:0] sched_sig0(input logic [31:0] x);
    return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
  endfunction

  function automatic logic [31:0] sched_sig1(input logic [31:0] x);
    return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
  endfunction

  function automatic logic [31:0] round_sum0(input logic [31:0] x);
    return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
  endfunction

  function automatic logic [31:0] round_sum1(input logic [31:0] x);
    return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
  endfunction

endpackage

@@ hw/rtl/sha256_byte_stream_hasher.sv @@
// Top level: byte-stream SHA-256 with padding sequencer and digest word output.
// Absorb: each accepted byte enters the block; the byte that fills a 64-byte block
//   starts the 64 rounds, the chaining update and the hand-back.
// Finish: 0x80, zeros to byte 56 (one step is a turn there), eight length bytes and
//   one or two compressions, then eight digest words at one per cycle unless stalled.
// Reset: chaining value to the SHA-256 initial value, byte count and fill to zero;
//   the block buffer is not cleared (each block is fully written before use).
`include "assert_macros.svh"

module sha256_byte_stream_hasher
  import sha256h_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        command_i,
  input  logic [7:0]  data_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] digest_word_o,
  output logic [2:0]  word_index_o,
  output logic        last_word_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PAD,
    ST_WAIT,
    ST_EMIT
  } state_e;

  localparam logic CMD_ABSORB = 1'b0;

  state_e      state_q;
  logic [60:0] byte_cnt_q;    // message length in bytes; bit count is this times 8
  logic [5:0]  fill_q;        // bytes in the current block
  logic        finishing_q;   // a finish is in progress
  logic        first_q;       // the 0x80 pad byte is still to go
  logic        len_q;         // now pushing the length bytes
  logic [3:0]  len_idx_q;     // length bytes pushed so far
  logic [2:0]  emit_idx_q;
  logic        out_valid_q;
  logic [31:0] out_word_q;
  logic [2:0]  out_index_q;
  logic        out_last_q;

  core_ctrl_t  core_ctrl;
  core_stat_t  core_stat;
  hash_t       core_hash;

  logic        in_acc;
  logic        out_load;
  logic        last_push;
  logic [63:0] len_bits;
  logic [7:0]  len_byte;

  assign in_acc    = in_valid_i && (state_q == ST_IDLE);
  assign out_load  = (state_q == ST_EMIT) && (!out_valid_q || !out_stall_i);
  assign last_push = (fill_q == 6'd63);
  assign len_bits  = {byte_cnt_q, 3'b000};
  // Length goes out big-endian: byte k is bits 63-8k down to 56-8k.
  assign len_byte  = len_bits[{~len_idx_q[2:0], 3'b000} +: 8];

  // Decide which byte, if any, enters the block this cycle.
  always_comb begin
    core_ctrl.push      = 1'b0;
    core_ctrl.push_byte = data_byte_i;
    core_ctrl.init      = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        core_ctrl.push = in_acc && (command_i == CMD_ABSORB);
      end
      ST_PAD: begin
        if (first_q) begin
          core_ctrl.push      = 1'b1;
          core_ctrl.push_byte = PAD_BYTE;
        end else if (!len_q) begin
          core_ctrl.push      = (fill_q != LEN_OFFSET);
          core_ctrl.push_byte = 8'h00;
        end else begin
          core_ctrl.push      = 1'b1;
          core_ctrl.push_byte = len_byte;
        end
      end
      ST_EMIT: begin
        // Restore the initial chaining value once the last word is loaded for output.
        core_ctrl.init = out_load && (emit_idx_q == 3'd7);
      end
      default: ;
    endcase
    core_ctrl.start = core_ctrl.push && last_push;
  end

  sha256h_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (core_ctrl),
    .stat_o (core_stat),
    .hash_o (core_hash)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      byte_cnt_q  <= '0;
      fill_q      <= '0;
      finishing_q <= 1'b0;
      first_q     <= 1'b0;
      len_q       <= 1'b0;
      len_idx_q   <= '0;
      emit_idx_q  <= '0;
      out_valid_q <= 1'b0;
      out_word_q  <= '0;
      out_index_q <= '0;
      out_last_q  <= 1'b0;
    end else begin
      if (core_ctrl.push) begin
        fill_q <= fill_q + 6'd1;
      end
      // Raise valid on a load, drop it once the waiting word is taken.
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_acc) begin
            if (command_i == CMD_ABSORB) begin
              byte_cnt_q <= byte_cnt_q + 61'd1;
              if (last_push) begin
                state_q <= ST_WAIT;
              end
            end else begin
              finishing_q <= 1'b1;
              first_q     <= 1'b1;
              len_q       <= 1'b0;
              len_idx_q   <= '0;
              state_q     <= ST_PAD;
            end
          end
        end
        ST_PAD: begin
          if (first_q) begin
            first_q <= 1'b0;
          end else if (!len_q) begin
            if (fill_q == LEN_OFFSET) begin
              len_q <= 1'b1;
            end
          end else begin
            len_idx_q <= len_idx_q + 4'd1;
          end
          if (core_ctrl.start) begin
            state_q <= ST_WAIT;
          end
        end
        ST_WAIT: begin
          // Hold until the compression lands, then resume where it left off.
          if (core_stat.done) begin
            if (!finishing_q) begin
              state_q <= ST_IDLE;
            end else if (len_q && len_idx_q == 4'd8) begin
              emit_idx_q <= '0;
              state_q    <= ST_EMIT;
            end else begin
              state_q <= ST_PAD;
            end
          end
        end
        ST_EMIT: begin
          if (out_load) begin
            out_word_q  <= core_hash[emit_idx_q];
            out_index_q <= emit_idx_q;
            out_last_q  <= (emit_idx_q == 3'd7);
            emit_idx_q  <= emit_idx_q + 3'd1;
            if (emit_idx_q == 3'd7) begin
              byte_cnt_q  <= '0;
              finishing_q <= 1'b0;
              len_q       <= 1'b0;
              state_q     <= ST_IDLE;
            end
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign in_stall_o    = (state_q != ST_IDLE);
  assign out_valid_o   = out_valid_q;
  assign digest_word_o = out_word_q;
  assign word_index_o  = out_index_q;
  assign last_word_o   = out_last_q;

  `SHA_ASSERT(a_stall_while_busy, core_stat.busy |-> in_stall_o)
  `SHA_ASSERT(a_start_on_full_block, core_ctrl.start |-> core_ctrl.push && fill_q == 6'd63)
  `SHA_ASSERT(a_emit_block_empty, state_q == ST_EMIT |-> fill_q == 6'd0)
  `SHA_ASSERT(a_index_steps, out_valid_o && !out_stall_i && !last_word_o |=> out_valid_o && word_index_o == $past(word_index_o) + 3'd1)

endmodule

@@ hw/rtl/sha256h_core.sv @@
// SHA-256 compression core: byte-fed schedule window and one shared round unit.
`include "assert_macros.svh"

module sha256h_core
  import sha256h_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  core_ctrl_t ctrl_i,
  output core_stat_t stat_o,
  output hash_t      hash_o
);

  typedef enum logic [1:0] {
    CORE_IDLE,
    CORE_ROUND,
    CORE_UPDATE
  } core_state_e;

  core_state_e state_q;
  logic [5:0]  rnd_q;
  logic        done_q;
  hash_t       h_q;
  hash_t       v_q;
  hash_t       v_d;
  // Block buffer and schedule window; the oldest word sits in the top bits.
  logic [511:0] w_q;

  logic [31:0] w0, w1, w9, w14, w_new;
  logic [31:0] t1, t2, ch, maj;

  assign w0  = w_q[511:480];
  assign w1  = w_q[479:448];
  assign w9  = w_q[223:192];
  assign w14 = w_q[63:32];

  always_comb begin
    w_new = w0 + sched_sig0(w1) + w9 + sched_sig1(w14);
    ch    = (v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]);
    maj   = (v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]);
    t1    = v_q[7] + round_sum1(v_q[4]) + ch + round_const(rnd_q) + w0;
    t2    = round_sum0(v_q[0]) + maj;
    v_d    = v_q;
    v_d[7] = v_q[6];
    v_d[6] = v_q[5];
    v_d[5] = v_q[4];
    v_d[4] = v_q[3] + t1;
    v_d[3] = v_q[2];
    v_d[2] = v_q[1];
    v_d[1] = v_q[0];
    v_d[0] = t1 + t2;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= CORE_IDLE;
      rnd_q   <= '0;
      done_q  <= 1'b0;
      h_q     <= SHA_IV;
    end else begin
      done_q <= 1'b0;
      unique case (state_q)
        CORE_IDLE: begin
          if (ctrl_i.init) begin
            h_q <= SHA_IV;
          end
          if (ctrl_i.start) begin
            rnd_q   <= '0;
            state_q <= CORE_ROUND;
          end
        end
        CORE_ROUND: begin
          rnd_q <= rnd_q + 6'd1;
          if (rnd_q == 6'd63) begin
            state_q <= CORE_UPDATE;
          end
        end
        CORE_UPDATE: begin
          for (int i = 0; i < 8; i++) begin
            h_q[i] <= h_q[i] + v_q[i];
          end
          done_q  <= 1'b1;
          state_q <= CORE_IDLE;
        end
        default: state_q <= CORE_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.push) begin
      w_q <= {w_q[503:0], ctrl_i.push_byte};
    end else if (state_q == CORE_ROUND) begin
      w_q <= {w_q[479:0], w_new};
    end
    if (state_q == CORE_IDLE && ctrl_i.start) begin
      v_q <= h_q;
    end else if (state_q == CORE_ROUND) begin
      v_q <= v_d;
    end
  end

  assign stat_o.busy = (state_q != CORE_IDLE);
  assign stat_o.done = done_q;
  assign hash_o      = h_q;

  `SHA_ASSERT(a_start_when_idle, ctrl_i.start |-> state_q == CORE_IDLE)
  `SHA_ASSERT(a_done_single, done_q |=> !done_q)
  `SHA_ASSERT(a_update_after_last_round, state_q == CORE_UPDATE |-> $past(rnd_q) == 6'd63)

endmodule
